// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the CDF sampler.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pccs_pkg.sv -----
// Package of the piecewise-constant CDF sampler: sizes, codes and FSM types.
// Depends on nothing; imported by the sampler top level.
package pccs_pkg;

    localparam int MAX_BINS = 256;
    localparam int ADDR_W   = $clog2(MAX_BINS + 1);   // cdf table address
    localparam int BIN_W    = $clog2(MAX_BINS);       // bin index, weight address
    localparam int IDX_W    = 9;                      // entry_index field
    localparam int NB_W     = 9;                      // bins_in_use register
    localparam int CDF_W    = 17;                     // Q1.16
    localparam int Q_W      = 16;                     // Q0.16 / Q8.8 words
    localparam int STEP_W   = 4;                      // divider step count
    localparam int CFG_IDX_W = 1;

    localparam logic [STEP_W-1:0] LAST_STEP = '1;

    localparam logic                 CMD_LOAD     = 1'b0;
    localparam logic                 CMD_SAMPLE   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_DONE,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_REMAP,
        PH_POS,
        PH_PDF
    } phase_t;

endpackage

// ----- rtl/core/piecewise_constant_cdf_sampler.sv -----
// Top level of the piecewise-constant inverse-CDF sampler: tables, search, divider.
// Depends on pccs_pkg and assert_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | command, entry_index, cdf_entry,
//           |                        | weight_entry, sample_u
//  output   | out_valid / out_stall  | bin_offset, remapped_u, position, pdf_value
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load beat writes the tables; loads may follow back to back.
// A sample beat holds in_stall through the search (a read and a compare per step, nine
// steps at 256 bins), the table reads and three divides (remap, position, pdf), any may be bypassed.
// Reset clears the sequencer, output valid and config registers (256 bins, zero integral), not tables.
// A finished result waits in the output register while new beats are accepted;
// a later sample holds in its final state until that register is free.
`include "assert_macros.svh"

module piecewise_constant_cdf_sampler (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [pccs_pkg::IDX_W-1:0]          entry_index,
    input  logic [pccs_pkg::CDF_W-1:0]          cdf_entry,
    input  logic [pccs_pkg::Q_W-1:0]            weight_entry,
    input  logic [pccs_pkg::Q_W-1:0]            sample_u,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pccs_pkg::BIN_W-1:0]          bin_offset,
    output logic [pccs_pkg::Q_W-1:0]            remapped_u,
    output logic [pccs_pkg::Q_W-1:0]            position,
    output logic [pccs_pkg::Q_W-1:0]            pdf_value,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pccs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pccs_pkg::Q_W-1:0]            cfg_data
);
    import pccs_pkg::*;

    // ------------------------------------------------------------------
    // Tables
    // ------------------------------------------------------------------
    logic [CDF_W-1:0] cdf_mem    [0:MAX_BINS];
    logic [Q_W-1:0]   weight_mem [0:MAX_BINS-1];

    logic [CDF_W-1:0]  cdf_rd_reg;
    logic [Q_W-1:0]    weight_rd_reg;
    logic [ADDR_W-1:0] cdf_addr;

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [NB_W-1:0]   bins_reg;
    logic [Q_W-1:0]    integral_reg;

    logic [NB_W-1:0]   n_reg,     n_next;
    logic [Q_W-1:0]    u_reg,     u_next;
    logic [ADDR_W-1:0] first_reg, first_next;
    logic [ADDR_W-1:0] len_reg,   len_next;
    logic [ADDR_W-1:0] mid_reg,   mid_next;
    logic [BIN_W-1:0]  bin_reg,   bin_next;
    logic [CDF_W-1:0]  lo_reg,    lo_next;
    logic [CDF_W-1:0]  hi_reg,    hi_next;

    // shared divider
    logic [CDF_W-1:0]  rem_reg,   rem_next;
    logic [Q_W-1:0]    quo_reg,   quo_next;
    logic [CDF_W-1:0]  dvs_reg,   dvs_next;
    logic [STEP_W-1:0] step_reg,  step_next;

    logic [Q_W-1:0]    remap_reg, remap_next;
    logic [Q_W-1:0]    pos_reg,   pos_next;
    logic [Q_W-1:0]    pdf_reg,   pdf_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]  bin_out_reg;
    logic [Q_W-1:0]    remap_out_reg;
    logic [Q_W-1:0]    pos_out_reg;
    logic [Q_W-1:0]    pdf_out_reg;

    logic in_accept;
    logic cfg_accept;
    logic out_take;
    logic out_load;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [NB_W-1:0]   n_eff;
    logic [ADDR_W-1:0] half;
    logic [ADDR_W-1:0] mid;
    logic [ADDR_W-1:0] first_m1;
    logic [ADDR_W-1:0] n_m1;
    logic [ADDR_W-1:0] bin_calc;
    logic [ADDR_W-1:0] bin_p1;
    logic              cdf_le_u;

    logic [Q_W-1:0]    du;
    logic [CDF_W-1:0]  span;
    logic [CDF_W-1:0]  op_hi;
    logic [Q_W-1:0]    op_lo;
    logic [CDF_W-1:0]  op_dvs;
    logic              bypass;
    logic [Q_W-1:0]    bypass_val;

    logic [CDF_W:0]    trial;
    logic              trial_ge;
    logic [Q_W-1:0]    step_quo;

    assign in_accept  = in_valid && !in_stall;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);

    assign out_valid  = out_valid_reg;
    assign bin_offset = bin_out_reg;
    assign remapped_u = remap_out_reg;
    assign position   = pos_out_reg;
    assign pdf_value  = pdf_out_reg;

    // bin count of zero acts as one; above the table size it saturates
    always_comb
    begin
        if (bins_reg == '0)
            n_eff = NB_W'(1);
        else if (bins_reg > NB_W'(MAX_BINS))
            n_eff = NB_W'(MAX_BINS);
        else
            n_eff = bins_reg;
    end

    // search window
    assign half     = len_reg >> 1;
    assign mid      = first_reg + half;
    assign cdf_le_u = (cdf_rd_reg <= {1'b0, u_reg});

    // last entry <= u, clamped to 0..n-1
    assign first_m1 = first_reg - ADDR_W'(1);
    assign n_m1     = ADDR_W'(n_reg) - ADDR_W'(1);
    always_comb
    begin
        if (first_reg == '0)
            bin_calc = '0;
        else if (first_m1 > n_m1)
            bin_calc = n_m1;
        else
            bin_calc = first_m1;
    end
    assign bin_p1 = ADDR_W'(bin_reg) + ADDR_W'(1);

    // divider operands per phase; bypass covers results known without dividing
    assign du   = ({1'b0, u_reg} > lo_reg) ? Q_W'({1'b0, u_reg} - lo_reg) : '0;
    assign span = hi_reg - lo_reg;

    always_comb
    begin
        op_hi      = '0;
        op_lo      = '0;
        op_dvs     = '0;
        bypass     = 1'b0;
        bypass_val = '0;
        case (phase_reg)
            PH_REMAP:
            begin
                op_hi  = CDF_W'(du);
                op_dvs = span;
                if (hi_reg <= lo_reg)
                begin
                    bypass     = 1'b1;
                    bypass_val = du;
                end
            end
            PH_POS:
            begin
                op_hi  = CDF_W'(bin_reg);
                op_lo  = remap_reg;
                op_dvs = CDF_W'(n_reg);
            end
            PH_PDF:
            begin
                op_hi  = CDF_W'(weight_rd_reg[Q_W-1:8]);
                op_lo  = {weight_rd_reg[7:0], 8'h00};
                op_dvs = CDF_W'(integral_reg);
                if (integral_reg == '0)
                begin
                    bypass     = 1'b1;
                    bypass_val = '0;
                end
            end
            default:
            begin
                bypass = 1'b1;
            end
        endcase
        // quotient of 2^16 or more saturates
        if (!bypass && (op_hi >= op_dvs))
        begin
            bypass     = 1'b1;
            bypass_val = '1;
        end
    end

    // one restoring division step
    assign trial    = {rem_reg, quo_reg[Q_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});
    assign step_quo = {quo_reg[Q_W-2:0], trial_ge};

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (command == CMD_SAMPLE))
                    state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (len_next == '0)
                    state_next = ST_RD_LO;
                else
                    state_next = ST_SRCH_RD;
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                if (!bypass)
                    state_next = ST_DIV_STEP;
                else if (phase_reg == PH_PDF)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_STEP:
            begin
                if (step_reg == LAST_STEP)
                begin
                    if (phase_reg == PH_PDF)
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIV_INIT;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls and next values
    // ------------------------------------------------------------------
    always_comb
    begin
        cdf_addr       = mid;
        phase_next     = phase_reg;
        n_next         = n_reg;
        u_next         = u_reg;
        first_next     = first_reg;
        len_next       = len_reg;
        mid_next       = mid_reg;
        bin_next       = bin_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        remap_next     = remap_reg;
        pos_next       = pos_reg;
        pdf_next       = pdf_reg;
        out_valid_next = out_valid_reg;

        if (out_take)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (command == CMD_SAMPLE))
                begin
                    n_next     = n_eff;
                    u_next     = sample_u;
                    first_next = '0;
                    len_next   = ADDR_W'(n_eff) + ADDR_W'(1);
                    phase_next = PH_REMAP;
                end
            end
            ST_SRCH_RD:
            begin
                cdf_addr = mid;
                mid_next = mid;
            end
            ST_SRCH_CMP:
            begin
                // advance past mid when its entry is <= u, else keep the lower half
                if (cdf_le_u)
                begin
                    first_next = mid_reg + ADDR_W'(1);
                    len_next   = len_reg - half - ADDR_W'(1);
                end
                else
                begin
                    len_next = half;
                end
            end
            ST_RD_LO:
            begin
                cdf_addr = bin_calc;
                bin_next = bin_calc[BIN_W-1:0];
            end
            ST_RD_HI:
            begin
                cdf_addr = bin_p1;
                lo_next  = cdf_rd_reg;
            end
            ST_RD_DONE:
            begin
                hi_next = cdf_rd_reg;
            end
            ST_DIV_INIT:
            begin
                if (bypass)
                begin
                    case (phase_reg)
                        PH_REMAP: remap_next = bypass_val;
                        PH_POS:   pos_next   = bypass_val;
                        PH_PDF:   pdf_next   = bypass_val;
                        default:  pdf_next   = bypass_val;
                    endcase
                    if (phase_reg == PH_REMAP)
                        phase_next = PH_POS;
                    else if (phase_reg == PH_POS)
                        phase_next = PH_PDF;
                end
                else
                begin
                    rem_next  = op_hi;
                    quo_next  = op_lo;
                    dvs_next  = op_dvs;
                    step_next = '0;
                end
            end
            ST_DIV_STEP:
            begin
                rem_next  = trial_ge ? CDF_W'(trial - {1'b0, dvs_reg}) : trial[CDF_W-1:0];
                quo_next  = step_quo;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    case (phase_reg)
                        PH_REMAP: remap_next = step_quo;
                        PH_POS:   pos_next   = step_quo;
                        PH_PDF:   pdf_next   = step_quo;
                        default:  pdf_next   = step_quo;
                    endcase
                    if (phase_reg == PH_REMAP)
                        phase_next = PH_POS;
                    else if (phase_reg == PH_POS)
                        phase_next = PH_PDF;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                cdf_addr = mid;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers with reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_REMAP;
            out_valid_reg <= 1'b0;
            bins_reg      <= NB_W'(MAX_BINS);
            integral_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_accept)
            begin
                case (cfg_index)
                    CFG_BINS:     bins_reg     <= cfg_data[NB_W-1:0];
                    CFG_INTEGRAL: integral_reg <= cfg_data;
                    default:      integral_reg <= integral_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        u_reg     <= u_next;
        first_reg <= first_next;
        len_reg   <= len_next;
        mid_reg   <= mid_next;
        bin_reg   <= bin_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        step_reg  <= step_next;
        remap_reg <= remap_next;
        pos_reg   <= pos_next;
        pdf_reg   <= pdf_next;
        if (out_load)
        begin
            bin_out_reg   <= bin_reg;
            remap_out_reg <= remap_reg;
            pos_out_reg   <= pos_reg;
            pdf_out_reg   <= pdf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Table memories: write on a load beat, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept && (command == CMD_LOAD) && (entry_index <= IDX_W'(MAX_BINS)))
            cdf_mem[entry_index[ADDR_W-1:0]] <= cdf_entry;
        cdf_rd_reg <= cdf_mem[cdf_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (command == CMD_LOAD) && (entry_index < IDX_W'(MAX_BINS)))
            weight_mem[entry_index[BIN_W-1:0]] <= weight_entry;
        weight_rd_reg <= weight_mem[bin_reg];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME_CYCLE(a_search_window, clk, rst_n, (state_reg == ST_SRCH_CMP),
        (len_reg != '0), "search compare with empty window")
    `ASSERT_SAME_CYCLE(a_bin_in_range, clk, rst_n, (state_reg == ST_RD_LO),
        (bin_calc < ADDR_W'(n_reg)), "bin outside 0..n-1")
    `ASSERT_SAME_CYCLE(a_div_remainder, clk, rst_n, (state_reg == ST_DIV_STEP),
        (rem_reg < dvs_reg), "divider remainder not below divisor")
    `ASSERT_NEXT_CYCLE(a_done_holds, clk, rst_n,
        ((state_reg == ST_DONE) && out_valid_reg && out_stall),
        (state_reg == ST_DONE), "result left while output slot busy")

endmodule
